/* rtl/core/pu_pkg.sv */
// Package for the permutation unranking block: word types, microcode
// types, step labels and the built-in factorial table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pu_pkg;

	localparam int MAX_N  = 20;
	localparam int LEN_W  = 5;
	localparam int RANK_W = 62;
	localparam int ELEM_W = 5;
	localparam int POS_W  = 5;
	localparam int PC_W   = 4;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [RANK_W-1:0] rank;
	} item_t;

	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic              last;
		logic              error;
	} result_t;

	// Datapath operation of one microcode step.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT,
		OP_SUB,
		OP_EMIT,
		OP_ERR
	} op_t;

	// Jump condition of one microcode step; when false the step counter advances.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_IDLE,
		C_BAD,
		C_GE,
		C_OUT_BUSY,
		C_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// Status from the datapath that the jump conditions test.
	typedef struct packed {
		logic in_valid;
		logic bad;
		logic ge;
		logic out_busy;
		logic more;
	} flags_t;

	// Step labels of the microprogram.
	localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
	localparam logic [PC_W-1:0] ST_CHECK    = 4'd1;
	localparam logic [PC_W-1:0] ST_INIT     = 4'd2;
	localparam logic [PC_W-1:0] ST_DIV      = 4'd3;
	localparam logic [PC_W-1:0] ST_EMIT     = 4'd4;
	localparam logic [PC_W-1:0] ST_LOOP     = 4'd5;
	localparam logic [PC_W-1:0] ST_DONE     = 4'd6;
	localparam logic [PC_W-1:0] ST_ERR      = 4'd7;
	localparam logic [PC_W-1:0] ST_ERR_DONE = 4'd8;

	// Factorials 0! to 20!; anything past that reads as zero.
	function automatic logic [RANK_W-1:0] fact(input logic [LEN_W-1:0] idx);
		logic [RANK_W-1:0] v;
		case (idx)
			5'd0:    v = 62'd1;
			5'd1:    v = 62'd1;
			5'd2:    v = 62'd2;
			5'd3:    v = 62'd6;
			5'd4:    v = 62'd24;
			5'd5:    v = 62'd120;
			5'd6:    v = 62'd720;
			5'd7:    v = 62'd5040;
			5'd8:    v = 62'd40320;
			5'd9:    v = 62'd362880;
			5'd10:   v = 62'd3628800;
			5'd11:   v = 62'd39916800;
			5'd12:   v = 62'd479001600;
			5'd13:   v = 62'd6227020800;
			5'd14:   v = 62'd87178291200;
			5'd15:   v = 62'd1307674368000;
			5'd16:   v = 62'd20922789888000;
			5'd17:   v = 62'd355687428096000;
			5'd18:   v = 62'd6402373705728000;
			5'd19:   v = 62'd121645100408832000;
			5'd20:   v = 62'd2432902008176640000;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/pu_rom.sv */
// Microcode store of the permutation unranking block: one control word per step.
// Depends on pu_pkg.
`default_nettype none

module pu_rom
	import pu_pkg::*;
(
	input  wire logic [PC_W-1:0] pc,
	output uword_t               uw
);

	always_comb begin
		case (pc)
			ST_WAIT:     uw = '{op: OP_LOAD, cond: C_IN_IDLE,  target: ST_WAIT};
			ST_CHECK:    uw = '{op: OP_NOP,  cond: C_BAD,      target: ST_ERR};
			ST_INIT:     uw = '{op: OP_INIT, cond: C_NEVER,    target: ST_WAIT};
			ST_DIV:      uw = '{op: OP_SUB,  cond: C_GE,       target: ST_DIV};
			ST_EMIT:     uw = '{op: OP_EMIT, cond: C_OUT_BUSY, target: ST_EMIT};
			ST_LOOP:     uw = '{op: OP_NOP,  cond: C_MORE,     target: ST_INIT};
			ST_DONE:     uw = '{op: OP_NOP,  cond: C_ALWAYS,   target: ST_WAIT};
			ST_ERR:      uw = '{op: OP_ERR,  cond: C_OUT_BUSY, target: ST_ERR};
			ST_ERR_DONE: uw = '{op: OP_NOP,  cond: C_ALWAYS,   target: ST_WAIT};
			default:     uw = '{op: OP_NOP,  cond: C_ALWAYS,   target: ST_WAIT};
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/pu_seq.sv */
// Step counter of the permutation unranking block, with conditional jumps.
// Depends on pu_pkg and pu_rom.
`default_nettype none

module pu_seq
	import pu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output uword_t      uw
);

	logic [PC_W-1:0] pc_q;
	logic            taken;

	pu_rom u_rom (
		.pc (pc_q),
		.uw (uw)
	);

	always_comb begin
		case (uw.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_IN_IDLE:  taken = !flags.in_valid;
			C_BAD:      taken = flags.bad;
			C_GE:       taken = flags.ge;
			C_OUT_BUSY: taken = flags.out_busy;
			C_MORE:     taken = flags.more;
			default:    taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else if (taken) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pu_dp.sv */
// Datapath of the permutation unranking block: remainder, digit counter,
// list of unused elements and the result register.
// Depends on pu_pkg.
`default_nettype none

module pu_dp
	import pu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire uword_t uw,
	input  wire logic   item_valid,
	input  wire item_t  item,
	input  wire logic   result_stall,
	output logic        result_valid,
	output result_t     result,
	output flags_t      flags
);

	logic [RANK_W-1:0] r_q;
	logic [RANK_W-1:0] f_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  m_q;
	logic [POS_W-1:0]  pos_q;
	logic              bad_q;
	logic [ELEM_W-1:0] list_q [MAX_N];
	logic              out_valid_q;
	result_t           out_q;
	logic              out_busy;

	assign out_busy     = out_valid_q && result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign flags.in_valid = item_valid;
	assign flags.bad      = bad_q || (r_q >= fact(n_q));
	assign flags.ge       = r_q >= f_q;
	assign flags.out_busy = out_busy;
	assign flags.more     = m_q != '0;

	// Working registers; the remainder holds rank minus one, zero for a zero rank.
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (item_valid) begin
					n_q   <= item.length;
					m_q   <= item.length;
					bad_q <= (item.length == '0) || (item.length > LEN_W'(MAX_N));
					r_q   <= (item.rank == '0) ? '0 : item.rank - 1'b1;
					for (int e = 0; e < MAX_N; e++) begin
						list_q[e] <= ELEM_W'(e + 1);
					end
				end
			end
			OP_INIT: begin
				f_q   <= fact(m_q - 1'b1);
				pos_q <= '0;
			end
			OP_SUB: begin
				if (flags.ge) begin
					r_q   <= r_q - f_q;
					pos_q <= pos_q + 1'b1;
				end
			end
			OP_EMIT: begin
				if (!out_busy) begin
					m_q <= m_q - 1'b1;
					// Close the gap left by the chosen element.
					for (int e = 0; e < MAX_N - 1; e++) begin
						if (POS_W'(e) >= pos_q) begin
							list_q[e] <= list_q[e + 1];
						end
					end
					list_q[MAX_N - 1] <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((uw.op == OP_EMIT || uw.op == OP_ERR) && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_busy) begin
			if (uw.op == OP_EMIT) begin
				out_q.element <= list_q[pos_q];
				out_q.last    <= (m_q == LEN_W'(1));
				out_q.error   <= 1'b0;
			end else if (uw.op == OP_ERR) begin
				out_q.element <= '0;
				out_q.last    <= 1'b1;
				out_q.error   <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/permutation_unrank.sv */
// Top level of the permutation unranking block: k-th permutation of 1..n.
// Depends on pu_pkg, pu_seq and pu_dp.
//
// Usage: an item word (length n, one-based rank k) enters on item/item_valid
// and is taken at an edge where item_valid is high and item_stall is low.
// The block answers with n result words on result/result_valid, one element
// of the permutation each, the final one marked with last. A rank of zero
// counts as rank one. A rank above n!, or a length of zero or above MAX_N,
// gives a single word with element zero, last and error set.
// One item is worked at a time. item_stall rises the cycle after an item is
// taken and falls when the sequencer is back in its wait step: after the loop
// and done steps that follow the loading of the last element word into the
// output register, or after the error-done step that follows the error word.
// Steps: for each digit d of the factorial number of the rank the sequencer
// runs init, d compare-subtract steps, a final compare, emit and loop. An
// item also passes the wait, check and done steps; an error item passes
// wait, check, error and error-done.
// The result register holds its word while result_stall is high, and the
// sequencer waits in its emit or error step until the register is free.
// Reset clears the step counter and the result valid flag; no other state
// needs clearing.
`default_nettype none

module permutation_unrank
	import pu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	input  wire item_t item,
	output logic       item_stall,
	output logic       result_valid,
	output result_t    result,
	input  wire logic  result_stall
);

	uword_t uw;
	flags_t flags;

	// Items are taken only in the wait step of the microprogram.
	assign item_stall = (uw.op != OP_LOAD);

	pu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	pu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.uw           (uw),
		.item_valid   (item_valid),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.flags        (flags)
	);

endmodule

`default_nettype wire

/* rtl/core/pu_checker.sv */
// Port-level checks of the permutation unranking block, bound to the top level.
// Depends on pu_pkg and permutation_unrank.
`default_nettype none

module pu_checker
	import pu_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire logic    result_valid,
	input wire result_t result,
	input wire logic    result_stall
);

	// A stalled result word stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Only one item is in flight: after a word is taken, input stalls.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item taken right after the first");

	// An error word is the single, final word of its item.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.last && result.element == '0)
		else $error("malformed error word");

	// A normal word carries an element in 1..MAX_N.
	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.error |->
			result.element != '0 && result.element <= ELEM_W'(MAX_N))
		else $error("element out of range");

endmodule

bind permutation_unrank pu_checker u_pu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result       (result),
	.result_stall (result_stall)
);

`default_nettype wire

/* tb/sv/unrank_checker.sv */
`timescale 1ns / 100ps
// Checker for permutation_unrank: watches both channels, predicts each permutation
// and compares every result word with the oldest prediction.
// Depends on pu_pkg for the word types and MAX_N.

module unrank_checker
	import pu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  item_t   item,
	input  logic    item_stall,
	input  logic    result_valid,
	input  result_t result,
	input  logic    result_stall,
	output int      fail_count,
	output int      words_pending
);

	result_t expected_words[$];

	initial begin
		fail_count    = 0;
		words_pending = 0;
	end

	function automatic logic [63:0] factorial(input int m);
		logic [63:0] acc;
		acc = 64'd1;
		for (int x = 2; x <= m; x++)
			acc = acc * x;
		return acc;
	endfunction

	// Walks the factorial digits of the rank, most significant first, and queues
	// one word per element; a bad length or rank queues the single error word.
	function automatic void predict_permutation(input item_t it);
		int          n;
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] pos;
		bit   [31:0] used;
		int          pick;
		result_t     w;
		n    = int'(it.length);
		k    = 64'(it.rank);
		used = '0;
		w    = '0;
		if (n == 0 || n > MAX_N) begin
			w.last  = 1'b1;
			w.error = 1'b1;
			expected_words = {expected_words, w};
			return;
		end
		if (k == 0)
			k = 64'd1;
		if (k > factorial(n)) begin
			w.last  = 1'b1;
			w.error = 1'b1;
			expected_words = {expected_words, w};
			return;
		end
		for (int i = 0; i < n; i++) begin
			f    = factorial(n - 1 - i);
			pos  = (k - 1) / f;
			k    = k - pos * f;
			pick = 0;
			for (int j = 1; j <= n; j++) begin
				if (!used[j] && pick == 0) begin
					if (pos == 0) begin
						used[j] = 1'b1;
						pick    = j;
					end else begin
						pos = pos - 1;
					end
				end
			end
			w.element = pick[ELEM_W-1:0];
			w.last    = (i == n - 1);
			w.error   = 1'b0;
			expected_words = {expected_words, w};
		end
	endfunction

	// A word leaving the block can never belong to an item taken at the same
	// edge, so the result side is checked before the new item is predicted.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with nothing expected: %s %0d %0d %0d",
						$time, "element/last/error", result.element, result.last,
						result.error);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (result !== want) begin
						$display("%0t: result word differs: expected element %0d last %0b error %0b,",
							$time, want.element, want.last, want.error);
						$display("%0t:     got element %0d last %0b error %0b",
							$time, result.element, result.last, result.error);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				predict_permutation(item);
			words_pending = expected_words.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Top of the permutation_unrank testbench: clock, reset, stimulus and verdict.
// Depends on pu_pkg, the permutation_unrank RTL and unrank_checker.

module tb;
	import pu_pkg::*;

	// Cycles with no word moving on either channel before the run is called hung.
	// The limit leaves plenty of room over the slowest legal item and the long
	// output hold.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 600;
	localparam int RANDOM_ITEMS   = 240;
	localparam int CALM_ITEMS     = 40;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	item_t   item;
	logic    item_stall;
	logic    result_valid;
	result_t result;
	logic    result_stall;

	int fail_count;
	int words_pending;
	int quiet_cycles;

	// Set by the stimulus to ask the receiver for one long hold; the receiver
	// clears it when the hold is over. Calm switches off idling on both sides.
	bit hold_results;
	bit calm;

	permutation_unrank uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

	unrank_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.item_stall    (item_stall),
		.result_valid  (result_valid),
		.result        (result),
		.result_stall  (result_stall),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offers one item word at the current falling edge and holds it steady until
	// the block takes it; returns at the following falling edge. Valid is only
	// raised here, so back-to-back items never lower and raise it in one step.
	task automatic send_word(input logic [LEN_W-1:0] n, input logic [RANK_W-1:0] k);
		item.length <= n;
		item.rank   <= k;
		item_valid  <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		item_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Sender pause: nothing is offered until every predicted word has arrived.
	task automatic drain;
		item_valid <= 1'b0;
		wait (words_pending == 0);
		@(negedge clk);
	endtask

	// Receiver: random stall bursts between free-running stretches, the one long
	// hold on request, and no stalls once calm.
	initial begin
		result_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
				hold_results = 1'b0;
			end else if (calm) begin
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 2) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 30) - 1) @(negedge clk);
			end
		end
	end

	// Watchdog: counts edges where no word moves on either channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [LEN_W-1:0]  n;
		logic [RANK_W-1:0] k;
		logic [63:0]       nf;
		logic [63:0]       raw;
		int                pick;

		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		hold_results = 1'b0;
		calm         = 1'b0;
		quiet_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The single-element permutation, with a zero rank that
		// must act as rank one and the first rank past 1!.
		send_word(5'd1, 62'd0);
		send_word(5'd1, 62'd1);
		send_word(5'd1, 62'd2);
		// Every permutation of three, in order, then one rank too far.
		for (int r = 1; r <= 7; r++)
			send_word(5'd3, RANK_W'(r));
		send_word(5'd2, 62'd0);
		send_word(5'd2, 62'd2);
		// Full length: first and last permutation, zero rank, and ranks above 20!
		// including the all-ones rank.
		send_word(5'd20, 62'd1);
		send_word(5'd20, 62'd2432902008176640000);
		send_word(5'd20, 62'd0);
		send_word(5'd20, 62'd2432902008176640001);
		send_word(5'd20, {RANK_W{1'b1}});
		// Lengths with no permutation: zero, just past the maximum, all ones.
		send_word(5'd0, 62'd5);
		send_word(5'd21, 62'd1);
		send_word(5'd31, {RANK_W{1'b1}});
		drain();

		// Long hold on the output while items keep coming: the result register
		// fills and the block has to stall its input.
		hold_results = 1'b1;
		send_word(5'd8, 62'd40320);
		send_word(5'd6, 62'd1);
		send_word(5'd12, 62'd123456789);
		send_word(5'd4, 62'd17);

		// Random part. Mostly ranks inside 1..n! with small lengths favored, plus
		// zero ranks, ranks past n!, raw 62-bit ranks and lengths out of range.
		for (int t = 0; t < RANDOM_ITEMS; t++) begin
			if (t == RANDOM_ITEMS / 2)
				drain();
			if (t == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if ($urandom_range(0, 3) == 0)
				n = LEN_W'($urandom_range(10, 20));
			else
				n = LEN_W'($urandom_range(1, 9));
			nf = 64'd1;
			for (int m = 2; m <= n; m++)
				nf = nf * m;
			raw  = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				n = ($urandom_range(0, 1) == 0) ? 5'd0 : LEN_W'($urandom_range(21, 31));
				k = raw[RANK_W-1:0];
			end else if (pick < 16) begin
				k = RANK_W'(nf + 64'd1 + 64'($urandom_range(0, 1000)));
			end else if (pick < 20) begin
				k = '0;
			end else if (pick < 26) begin
				k = raw[RANK_W-1:0];
			end else begin
				k = RANK_W'(64'd1 + raw % nf);
			end
			send_word(n, k);
			if (!calm && $urandom_range(0, 2) == 0)
				idle_sender($urandom_range(1, 10));
		end

		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pu_pkg.sv
rtl/core/pu_rom.sv
rtl/core/pu_seq.sv
rtl/core/pu_dp.sv
rtl/core/permutation_unrank.sv
rtl/core/pu_checker.sv
tb/sv/unrank_checker.sv
tb/sv/tb.sv
